// File: rtl/recent_id_duplicate_filter_macros.svh
// Assertion macros for the recent-id duplicate filter checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RECENT_ID_DUPLICATE_FILTER_MACROS_SVH
`define RECENT_ID_DUPLICATE_FILTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define RID_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define RID_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rid_pkg.sv
// Shared types and constants for the recent-id duplicate filter.
// No dependencies; imported by rid_cell, rid_scan and the top level.
`default_nettype none

package rid_pkg;

    localparam int ENTRIES_DEF  = 256;
    localparam int ID_BYTES_DEF = 8;
    localparam int MSG_ID_W     = 64;
    // Hit bits folded per scan cycle.
    localparam int GROUP_W      = 16;

    typedef struct packed {
        logic shift;    // take the neighbour's id
        logic compare;  // register the match against the query
    } cell_ctl_t;

    typedef struct packed {
        logic start;    // clear count and accumulator
        logic run;      // fold one group of hit bits
    } scan_ctl_t;

endpackage

`default_nettype wire

// File: rtl/rid_cell.sv
// One storage cell of the id chain: holds an id, shifts it on, compares it.
// Depends on rid_pkg.
`default_nettype none

module rid_cell #(
    parameter int ID_W  = 64,
    parameter int FW    = 9,
    parameter int INDEX = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rid_pkg::cell_ctl_t ctl,
    input  wire logic [FW-1:0]    fill,
    input  wire logic [ID_W-1:0]  prev_id,
    input  wire logic [ID_W-1:0]  query,
    output logic      [ID_W-1:0]  id,
    output logic                  hit
);
    import rid_pkg::*;

    logic [ID_W-1:0] data_reg;
    logic            hit_reg;
    logic            valid;

    // Cell k holds the k-th most recent id; only the first fill cells count.
    assign valid = (FW'(INDEX) < fill);

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            data_reg <= prev_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.compare)
        begin
            hit_reg <= valid && (data_reg == query);
        end
    end

    assign id  = data_reg;
    assign hit = hit_reg;

endmodule

`default_nettype wire

// File: rtl/rid_scan.sv
// Folds the per-cell hit bits into one flag, one group per cycle while run is set.
// Depends on rid_pkg.
`default_nettype none

module rid_scan #(
    parameter int GROUPS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire rid_pkg::scan_ctl_t             ctl,
    input  wire logic [GROUPS*rid_pkg::GROUP_W-1:0] hits,
    output logic                                last,
    output logic                                hit
);
    import rid_pkg::*;

    localparam int CW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          acc_reg;
    logic          acc_next;
    logic          group_hit;

    assign group_hit = |hits[int'(cnt_reg)*GROUP_W +: GROUP_W];

    always_comb
    begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        if (ctl.start)
        begin
            cnt_next = '0;
            acc_next = 1'b0;
        end
        else if (ctl.run)
        begin
            cnt_next = cnt_reg + 1'b1;
            acc_next = acc_reg | group_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            acc_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            acc_reg <= acc_next;
        end
    end

    assign last = (cnt_reg == CW'(GROUPS - 1));
    assign hit  = acc_reg;

endmodule

`default_nettype wire

// File: rtl/recent_id_duplicate_filter.sv
// Top level of the recent-id duplicate filter: cell chain, scanner, sequencer.
// Depends on rid_pkg, rid_cell and rid_scan.
//
//   channel  | handshake        | payload
//   ---------+------------------+----------------
//   command  | start / busy     | op, msg_id
//   result   | done (strobe)    | duplicate
//
// A record-only beat goes from idle straight to the finish state.
// A check beat runs a compare across the chain, then a scan in which
// the scanner folds 16 hit bits per cycle, then the finish state, which
// shifts the chain unless the id was a duplicate, and strobes done.
// Reset clears the sequencer, fill count, scanner and hit flags; the stored ids need none.
// done is high for one cycle with busy; the result cannot be stalled.
`default_nettype none

module recent_id_duplicate_filter #(
    parameter int ENTRIES  = rid_pkg::ENTRIES_DEF,
    parameter int ID_BYTES = rid_pkg::ID_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         op,
    input  wire logic [rid_pkg::MSG_ID_W-1:0] msg_id,
    output logic                              done,
    output logic                              duplicate
);
    import rid_pkg::*;

    localparam int ID_W   = 8 * ID_BYTES;
    localparam int FW     = $clog2(ENTRIES + 1);
    localparam int GROUPS = (ENTRIES + GROUP_W - 1) / GROUP_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;
    logic [ID_W-1:0] query_reg;
    logic            op_reg;

    cell_ctl_t       cell_ctl;
    scan_ctl_t       scan_ctl;
    logic            scan_last;
    logic            scan_hit;
    logic            record;

    logic [ID_W-1:0]             cell_id [ENTRIES];
    logic [GROUPS*GROUP_W-1:0]   hit_pad;

    // A hit drops the beat without touching the store.
    assign record = op_reg | ~scan_hit;

    assign cell_ctl.compare = (state_reg == ST_CMP);
    assign cell_ctl.shift   = (state_reg == ST_FIN) && record;
    assign scan_ctl.start   = (state_reg == ST_CMP);
    assign scan_ctl.run     = (state_reg == ST_SCAN);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = op ? ST_FIN : ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
                if (record && (fill_reg < FW'(ENTRIES)))
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    // Hold the accepted beat; unused id bits are dropped here.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            query_reg <= msg_id[ID_W-1:0];
            op_reg    <= op;
        end
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        logic [ID_W-1:0] prev_id;
        if (g == 0)
        begin : g_head
            assign prev_id = query_reg;
        end
        else
        begin : g_body
            assign prev_id = cell_id[g-1];
        end

        rid_cell #(
            .ID_W  (ID_W),
            .FW    (FW),
            .INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (cell_ctl),
            .fill    (fill_reg),
            .prev_id (prev_id),
            .query   (query_reg),
            .id      (cell_id[g]),
            .hit     (hit_pad[g])
        );
    end

    if (GROUPS * GROUP_W > ENTRIES)
    begin : g_pad
        assign hit_pad[GROUPS*GROUP_W-1:ENTRIES] = '0;
    end

    rid_scan #(
        .GROUPS (GROUPS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .hits  (hit_pad),
        .last  (scan_last),
        .hit   (scan_hit)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_FIN);
    assign duplicate = done & ~op_reg & scan_hit;

endmodule

`default_nettype wire

// File: rtl/rid_checker.sv
// Port-level checker for the recent-id duplicate filter, bound to the top level.
// Depends on recent_id_duplicate_filter_macros.svh.
`default_nettype none
`include "recent_id_duplicate_filter_macros.svh"

module rid_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         op,
    input wire logic                         done,
    input wire logic                         duplicate
);
    logic accept;

    assign accept = start && !busy;

    `RID_ASSERT_IMP(a_dup_needs_done, duplicate, done, "duplicate outside a result beat")
    `RID_ASSERT_IMP(a_done_while_busy, done, busy, "result strobe while idle")
    `RID_ASSERT_NXT(a_done_frees, done, !busy, "busy held after result beat")
    `RID_ASSERT_NXT(a_record_fast, accept && op, done && !duplicate, "record-only beat late or dup")
    `RID_ASSERT_NXT(a_accept_busy, accept && !op, busy && !done, "check beat finished too early")

endmodule

bind recent_id_duplicate_filter rid_checker u_rid_checker (.*);

`default_nettype wire

// File: bench/recent_id_duplicate_filter_test.sv
`timescale 1ns / 1ps
// Self-checking bench for recent_id_duplicate_filter: directed table, then random
// check/record beats with a duplicate predictor of its own. Needs rid_pkg and the RTL.

module recent_id_duplicate_filter_test;
    import rid_pkg::*;

    localparam int ENTRIES  = ENTRIES_DEF;
    localparam int ID_BYTES = ID_BYTES_DEF;
    localparam logic [MSG_ID_W-1:0] ID_MASK = {MSG_ID_W{1'b1}} >> (MSG_ID_W - 8 * ID_BYTES);
    localparam logic OP_CHECK  = 1'b0;
    localparam logic OP_RECORD = 1'b1;
    localparam int RANDOM_BEATS = 850;
    localparam int SETTLE_CYCLES = 24;
    localparam int HISTORY_DEPTH = ENTRIES + 44;

    typedef struct packed {
        logic                op;
        logic [MSG_ID_W-1:0] id;
        logic                typed;  // expected verdict given in the row
        logic                dup;
    } table_row_t;

    localparam int ROWS = 24;
    localparam table_row_t DIRECTED [ROWS] = '{
        '{OP_CHECK,  64'h0000_0000_0000_0000, 1'b1, 1'b0},  // empty store
        '{OP_CHECK,  64'h0000_0000_0000_0000, 1'b1, 1'b1},
        '{OP_RECORD, 64'h0000_0000_0000_0000, 1'b1, 1'b0},  // stored id recorded again
        '{OP_CHECK,  64'h0000_0000_0000_0000, 1'b1, 1'b1},
        '{OP_CHECK,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0},
        '{OP_CHECK,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1},
        '{OP_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0},
        '{OP_CHECK,  64'h8000_0000_0000_0000, 1'b1, 1'b0},
        '{OP_CHECK,  64'h0000_0000_0000_0001, 1'b1, 1'b0},
        '{OP_CHECK,  64'h8000_0000_0000_0000, 1'b1, 1'b1},
        '{OP_CHECK,  64'h0000_0000_0000_0001, 1'b1, 1'b1},
        '{OP_CHECK,  64'h0123_4567_89AB_CDEF, 1'b1, 1'b0},
        '{OP_CHECK,  64'hFEDC_BA98_7654_3210, 1'b1, 1'b0},
        '{OP_RECORD, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0},
        '{OP_CHECK,  64'h0123_4567_89AB_CDEE, 1'b1, 1'b0},  // one bit off
        '{OP_CHECK,  64'h0123_4567_89AB_CDEF, 1'b1, 1'b1},
        '{OP_CHECK,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0},
        '{OP_CHECK,  64'h5555_5555_5555_5555, 1'b1, 1'b0},
        '{OP_CHECK,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1},
        '{OP_RECORD, 64'h5555_5555_5555_5555, 1'b1, 1'b0},
        '{OP_CHECK,  64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
        '{OP_CHECK,  64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0},
        '{OP_CHECK,  64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
        '{OP_CHECK,  64'h5555_5555_5555_5555, 1'b0, 1'b0}
    };

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                op;
    logic [MSG_ID_W-1:0] msg_id;
    logic                done;
    logic                duplicate;

    // expectation attached to the beat on the bus
    logic beat_typed;
    logic beat_dup;

    // predictor state
    logic [MSG_ID_W-1:0] stored_ids [ENTRIES];
    int unsigned         next_slot;
    int unsigned         valid_count;
    logic [MSG_ID_W-1:0] id_history [$];

    logic expected_dup_q [$];
    logic predicted;
    int   mismatches;
    int   checks_seen;
    int   hits_predicted;
    int   records_seen;

    recent_id_duplicate_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .msg_id    (msg_id),
        .done      (done),
        .duplicate (duplicate)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[recent_id_duplicate_filter] ERROR");
        $finish;
    end

    // Work out the verdict for one accepted beat and update the store.
    function automatic logic predict_duplicate(input logic beat_op,
                                               input logic [MSG_ID_W-1:0] raw_id);
        logic [MSG_ID_W-1:0] id;
        logic hit;
        id  = raw_id & ID_MASK;
        hit = 1'b0;
        if (beat_op == OP_CHECK)
            for (int i = 0; i < valid_count; i++)
                if (stored_ids[i] == id)
                    hit = 1'b1;
        if (!hit)
        begin
            stored_ids[next_slot] = id;
            next_slot = (next_slot + 1) % ENTRIES;
            if (valid_count < ENTRIES)
                valid_count++;
            id_history.push_back(id);
            if (id_history.size() > HISTORY_DEPTH)
                void'(id_history.pop_front());
        end
        return hit;
    endfunction

    task automatic note_mismatch(input string what, input logic exp_v, input logic act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected duplicate=%0b, got %0b", $realtime, what, exp_v, act_v);
    endtask

    // Pop the verdict before taking a new beat: done never shares an edge with an accept.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_dup_q.size() == 0)
                    note_mismatch("result with no beat pending", 1'bx, duplicate);
                else if (duplicate !== expected_dup_q[0])
                    note_mismatch("duplicate flag", expected_dup_q.pop_front(), duplicate);
                else
                    void'(expected_dup_q.pop_front());
            end
            if (start && !busy)
            begin
                predicted = predict_duplicate(op, msg_id);
                expected_dup_q.push_back(beat_typed ? beat_dup : predicted);
                if (op == OP_CHECK)
                    checks_seen++;
                else
                    records_seen++;
                if (predicted)
                    hits_predicted++;
            end
        end
    end

    // Present one beat and hold it until the block takes it.
    task automatic send_beat(input logic beat_op, input logic [MSG_ID_W-1:0] id,
                             input logic typed, input logic exp_dup);
        start      <= 1'b1;
        op         <= beat_op;
        msg_id     <= id;
        beat_typed <= typed;
        beat_dup   <= exp_dup;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Drop start and wait for every verdict, then let the block settle.
    task automatic drain;
        int guard;
        guard = 0;
        start <= 1'b0;
        while (expected_dup_q.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // End a burst with a gap, or keep start high for the next beat.
    int burst_left;
    task automatic pace;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        start <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 8);
    endtask

    initial
    begin
        int kind;
        int age;
        int span;
        int n_hist;
        logic beat_op;
        logic [MSG_ID_W-1:0] id;

        rst_n       = 1'b0;
        start       = 1'b0;
        op          = 1'b0;
        msg_id      = '0;
        beat_typed  = 1'b0;
        beat_dup    = 1'b0;
        next_slot   = 0;
        valid_count = 0;
        mismatches  = 0;
        checks_seen = 0;
        hits_predicted = 0;
        records_seen   = 0;
        burst_left  = 0;
        foreach (stored_ids[i])
            stored_ids[i] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < ROWS; r++)
        begin
            send_beat(DIRECTED[r].op, DIRECTED[r].id, DIRECTED[r].typed, DIRECTED[r].dup);
            pace();
        end
        drain();

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            n_hist  = id_history.size();
            kind    = $urandom_range(0, 99);
            beat_op = OP_CHECK;
            id      = {$urandom, $urandom};
            if (valid_count > 0)
            begin
                if (kind >= 30 && kind < 55)
                begin
                    // live entry: expect a hit
                    age = $urandom_range(1, valid_count);
                    id  = id_history[n_hist - age];
                end
                else if (kind >= 55 && kind < 70)
                begin
                    // around the eviction boundary
                    span = (n_hist < ENTRIES + 6) ? n_hist : ENTRIES + 6;
                    age  = (span > ENTRIES - 6) ? $urandom_range(ENTRIES - 6, span)
                                                : $urandom_range(1, span);
                    id   = id_history[n_hist - age];
                end
                else if (kind >= 80 && kind < 90)
                begin
                    beat_op = OP_RECORD;
                    id = id_history[n_hist - $urandom_range(1, valid_count)];
                end
                else if (kind >= 90)
                begin
                    id = id_history[n_hist - $urandom_range(1, valid_count)]
                         ^ (64'd1 << $urandom_range(0, MSG_ID_W - 1));
                end
            end
            if (kind >= 70 && kind < 80)
                beat_op = OP_RECORD;
            send_beat(beat_op, id, 1'b0, 1'b0);
            if (n == 300 || n == 600)
                drain();
            else
                pace();
        end

        drain();
        if (expected_dup_q.size() != 0)
            note_mismatch("verdicts never delivered", 1'bx, 1'bx);

        $display("Covered %0d checks (%0d duplicates) and %0d record-only beats;",
                 checks_seen, hits_predicted, records_seen);
        $display("store of %0d ids wrapped, %0d mismatches.", ENTRIES, mismatches);
        if (mismatches == 0)
            $display("[recent_id_duplicate_filter] OK");
        else
            $display("[recent_id_duplicate_filter] ERROR");
        $finish;
    end

endmodule

// File: recent_id_duplicate_filter.f
+incdir+rtl
rtl/rid_pkg.sv
rtl/rid_cell.sv
rtl/rid_scan.sv
rtl/recent_id_duplicate_filter.sv
rtl/rid_checker.sv
bench/recent_id_duplicate_filter_test.sv
